// ===== rtl/core/dqsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and lookup tables for the dual quadrature step counter.
// No dependencies.
package dqsc_pkg;

   localparam int LEVELS_W = 2;
   localparam int SAMPLE_W = 4;
   localparam int COUNT_W  = 8;
   localparam int STEP_W   = 3;
   localparam int BAR_W    = 8;

   typedef logic [LEVELS_W-1:0] levels_type;
   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [STEP_W-1:0]   step_type;
   typedef logic [BAR_W-1:0]    bar_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_DOWN = 2'd1,
      DIR_UP   = 2'd2
   } dir_type;

   // old phase pair in bits 3:2, new phase pair in bits 1:0
   function automatic dir_type dir_lookup(input logic [3:0] idx);
      dir_type d;
      case (idx) inside
         4'd1, 4'd7, 4'd8, 4'd14: d = DIR_UP;
         4'd2, 4'd4, 4'd11, 4'd13: d = DIR_DOWN;
         default: d = DIR_NONE;
      endcase
      return d;
   endfunction

   function automatic step_type step_lookup(input logic [1:0] toggles);
      step_type s;
      case (toggles)
         2'b00: s = step_type'(1);
         2'b01: s = step_type'(2);
         2'b10: s = step_type'(4);
         default: s = step_type'(0);
      endcase
      return s;
   endfunction

   function automatic bar_type bar_lookup(input step_type step);
      bar_type b;
      case (step)
         step_type'(0): b = 8'hC0;
         step_type'(1): b = 8'h01;
         step_type'(2): b = 8'h83;
         step_type'(4): b = 8'h4F;
         default: b = 8'hFF;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/dqsc_debounce.sv =====
`timescale 1ns / 1ps
// Shift-register debouncer for one active-low button.
// Depends on nothing beyond the DEBOUNCE_SAMPLES parameter.
module dqsc_debounce #(
   parameter int DEBOUNCE_SAMPLES = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  logic level,
   output logic press
);

   // only the newest DEBOUNCE_SAMPLES + 1 samples are kept, since older samples do not affect the match
   localparam int HIST_W = DEBOUNCE_SAMPLES + 1;
   localparam logic [HIST_W-1:0] TARGET = {1'b1, {DEBOUNCE_SAMPLES{1'b0}}};

   logic [HIST_W-1:0] history_ff;
   logic [HIST_W-1:0] history_in;

   assign history_in = {history_ff[HIST_W-2:0], level};
   assign press      = shift_en && (history_in == TARGET);

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else if (shift_en) begin
         history_ff <= history_in;
      end
   end

endmodule

// ===== rtl/core/dqsc_counter.sv =====
`timescale 1ns / 1ps
// Quadrature decode of two encoders and the wrapping position count.
// Depends on dqsc_pkg.
module dqsc_counter (
   input  logic                clock,
   input  logic                reset,
   input  logic                update_en,
   input  dqsc_pkg::sample_type sample,
   input  dqsc_pkg::step_type   step,
   output dqsc_pkg::count_type  count_next
);
   import dqsc_pkg::*;

   sample_type prev_ff;
   count_type  count_ff;
   dir_type    dir_a;
   dir_type    dir_b;
   count_type  step_ext;
   count_type  after_a;
   logic       changed;

   assign changed  = (sample != prev_ff);
   assign dir_a    = dir_lookup({prev_ff[1:0], sample[1:0]});
   assign dir_b    = dir_lookup({prev_ff[3:2], sample[3:2]});
   assign step_ext = count_type'(step);

   always_comb begin
      after_a    = count_ff;
      count_next = count_ff;
      if (changed) begin
         case (dir_a)
            DIR_UP:   after_a = count_ff + step_ext;
            DIR_DOWN: after_a = count_ff - step_ext;
            default:  after_a = count_ff;
         endcase
         case (dir_b)
            DIR_UP:   count_next = after_a + step_ext;
            DIR_DOWN: count_next = after_a - step_ext;
            default:  count_next = after_a;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else if (update_en) begin
         prev_ff  <= sample;
         count_ff <= count_next;
      end
   end

endmodule

// ===== rtl/core/dual_quadrature_step_counter_top.sv =====
`timescale 1ns / 1ps
// Dual quadrature step counter, top level.
// A request is captured in the input register, then moves to the result register once that is free.
// Throughput: one request per cycle; the result register holds while rsp_ready is low.
// Reset (synchronous, active high) clears debouncers, toggles, previous sample and count;
// step resets to 1. Depends on dqsc_pkg, dqsc_debounce, dqsc_counter.
module dual_quadrature_step_counter_top #(
   parameter int DEBOUNCE_SAMPLES = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dqsc_pkg::levels_type req_button_levels,
   input  dqsc_pkg::sample_type req_encoder_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dqsc_pkg::count_type  rsp_count,
   output dqsc_pkg::step_type   rsp_step_size,
   output dqsc_pkg::bar_type    rsp_bargraph_pattern
);
   import dqsc_pkg::*;

   logic       in_valid_ff;
   levels_type in_levels_ff;
   sample_type in_sample_ff;
   logic       out_valid_ff;
   count_type  out_count_ff;
   step_type   out_step_ff;
   bar_type    out_bar_ff;

   logic [1:0] toggle_ff;
   logic [1:0] toggle_in;
   step_type   step_ff;
   step_type   step_in;
   logic [1:0] press;
   logic       advance;
   count_type  count_next;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   dqsc_debounce #(.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)) u_deb0 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (advance),
      .level    (in_levels_ff[0]),
      .press    (press[0])
   );

   dqsc_debounce #(.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)) u_deb1 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (advance),
      .level    (in_levels_ff[1]),
      .press    (press[1])
   );

   // toggles commute, so both buttons fold into one xor
   assign toggle_in = toggle_ff ^ press;
   assign step_in   = (press != 2'b00) ? step_lookup(toggle_in) : step_ff;

   dqsc_counter u_counter (
      .clock      (clock),
      .reset      (reset),
      .update_en  (advance),
      .sample     (in_sample_ff),
      .step       (step_in),
      .count_next (count_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         toggle_ff    <= '0;
         step_ff      <= step_type'(1);
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            toggle_ff    <= toggle_in;
            step_ff      <= step_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_levels_ff <= req_button_levels;
         in_sample_ff <= req_encoder_sample;
      end
      if (advance) begin
         out_count_ff <= count_next;
         out_step_ff  <= step_in;
         out_bar_ff   <= bar_lookup(step_in);
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_count            = out_count_ff;
   assign rsp_step_size        = out_step_ff;
   assign rsp_bargraph_pattern = out_bar_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dual_quadrature_step_counter_top: directed rows, then shaped random
// button presses and encoder walks under four handshake mixes and one long hold-off.
// Depends on dqsc_pkg and the counter RTL.
module testbench;
   import dqsc_pkg::*;

   localparam int PRESS_SAMPLES = 12;
   localparam logic [15:0] PRESS_MASK = 16'hFFFF << (PRESS_SAMPLES + 1);
   localparam logic [15:0] PRESS_TARGET = PRESS_MASK | (16'h1 << PRESS_SAMPLES);
   localparam int RANDOM_REQUESTS = 1730;
   localparam int PHASE_LENGTH = RANDOM_REQUESTS / 4;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      count_type count;
      step_type  step;
      bar_type   bar;
   } reading_type;

   typedef struct {
      levels_type  levels;
      sample_type  enc;
      bit          fixed;
      reading_type reading;
   } request_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   levels_type req_button_levels = 2'b11;
   sample_type req_encoder_sample = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   count_type  rsp_count;
   step_type   rsp_step_size;
   bar_type    rsp_bargraph_pattern;

   logic [15:0] press_history [2] = '{16'h0, 16'h0};
   logic [1:0]  toggles = 2'b00;
   step_type    step_now = 3'd1;
   sample_type  last_enc = '0;
   count_type   position = '0;

   request_type requests [$];
   reading_type pending_readings [$];
   int          directed_count;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   bit          long_hold_request = 1'b0;
   int          mismatches = 0;
   int          requests_sent = 0;
   int          readings_checked = 0;
   int          presses_seen = 0;
   int          turns_seen = 0;
   bit [7:0]    steps_seen = '0;

   dual_quadrature_step_counter_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_button_levels(req_button_levels),
      .req_encoder_sample(req_encoder_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_count(rsp_count),
      .rsp_step_size(rsp_step_size),
      .rsp_bargraph_pattern(rsp_bargraph_pattern)
   );

   always #6 clock = ~clock;

   function automatic dir_type turn_direction(input logic [1:0] old_phase,
                                              input logic [1:0] new_phase);
      logic [1:0] delta;
      delta = {new_phase[1], ^new_phase} - {old_phase[1], ^old_phase};
      case (delta)
         2'd1: return DIR_UP;
         2'd3: return DIR_DOWN;
         default: return DIR_NONE;
      endcase
   endfunction

   function automatic bit debounce_press(input int idx, input logic level);
      press_history[idx] = {press_history[idx][14:0], level} | PRESS_MASK;
      return press_history[idx] == PRESS_TARGET;
   endfunction

   function automatic void apply_turn(input dir_type dir);
      if (dir == DIR_UP) begin
         position = position + count_type'(step_now);
      end else if (dir == DIR_DOWN) begin
         position = position - count_type'(step_now);
      end
      if (dir != DIR_NONE) turns_seen++;
   endfunction

   function automatic reading_type advance_counter(input levels_type levels,
                                                   input sample_type enc);
      bar_type bar;
      if (debounce_press(1, levels[1])) begin
         toggles[1] = ~toggles[1];
         presses_seen++;
      end
      if (debounce_press(0, levels[0])) begin
         toggles[0] = ~toggles[0];
         presses_seen++;
      end
      case (toggles)
         2'b00: step_now = 3'd1;
         2'b01: step_now = 3'd2;
         2'b10: step_now = 3'd4;
         default: step_now = 3'd0;
      endcase
      if (enc != last_enc) begin
         apply_turn(turn_direction(last_enc[1:0], enc[1:0]));
         apply_turn(turn_direction(last_enc[3:2], enc[3:2]));
         last_enc = enc;
      end
      case (step_now)
         3'd0: bar = 8'hC0;
         3'd1: bar = 8'h01;
         3'd2: bar = 8'h83;
         3'd4: bar = 8'h4F;
         default: bar = 8'hFF;
      endcase
      return {position, step_now, bar};
   endfunction

   task automatic add_row(input levels_type levels, input sample_type enc, input bit fixed,
                          input count_type count, input step_type step, input bar_type bar);
      request_type r;
      r.levels = levels;
      r.enc = enc;
      r.fixed = fixed;
      r.reading = {count, step, bar};
      requests.push_back(r);
   endtask

   function automatic logic [1:0] wander(input logic [1:0] pos);
      int m;
      m = $urandom_range(0, 9);
      if (m < 4) return pos + 2'd1;
      if (m < 7) return pos - 2'd1;
      if (m < 9) return pos;
      return pos + 2'd2;
   endfunction

   task automatic build_random_requests(input int total);
      logic [1:0] a_pos;
      logic [1:0] b_pos;
      int         kind;
      int         len;
      int         held;
      levels_type pressed;
      levels_type levels;
      sample_type enc;
      a_pos = 2'd0;
      b_pos = 2'd0;
      while (total > 0) begin
         kind = $urandom_range(0, 9);
         held = $urandom_range(9, 16);
         pressed = levels_type'($urandom_range(1, 3));
         len = (kind < 4) ? $urandom_range(1, 3) + held : $urandom_range(4, 30);
         for (int t = 0; t < len && total > 0; t++) begin
            if (kind < 4) begin
               levels = (t >= len - held) ? ~pressed : 2'b11;
            end else if (kind < 8) begin
               levels = 2'b11;
            end else begin
               levels = levels_type'($urandom_range(0, 3));
            end
            if (kind < 8) begin
               a_pos = wander(a_pos);
               b_pos = wander(b_pos);
               enc = {b_pos ^ (b_pos >> 1), a_pos ^ (a_pos >> 1)};
            end else begin
               enc = sample_type'($urandom_range(0, 15));
            end
            add_row(levels, enc, 1'b0, '0, '0, '0);
            total--;
         end
      end
   endtask

   // request side
   initial begin
      reading_type predicted;
      int          phase;
      add_row(2'b11, 4'h0, 1'b1, 8'd0, 3'd1, 8'h01);
      add_row(2'b11, 4'h1, 1'b0, '0, '0, '0);
      add_row(2'b11, 4'h1, 1'b0, '0, '0, '0);
      add_row(2'b11, 4'h3, 1'b0, '0, '0, '0);
      add_row(2'b11, 4'h0, 1'b0, '0, '0, '0);
      add_row(2'b11, 4'hF, 1'b1, 8'd2, 3'd1, 8'h01);
      repeat (11) add_row(2'b00, 4'hF, 1'b0, '0, '0, '0);
      add_row(2'b00, 4'hF, 1'b1, 8'd2, 3'd0, 8'hC0);
      add_row(2'b00, 4'hE, 1'b1, 8'd2, 3'd0, 8'hC0);
      add_row(2'b10, 4'hC, 1'b0, '0, '0, '0);
      add_row(2'b01, 4'h5, 1'b0, '0, '0, '0);
      add_row(2'b11, 4'hA, 1'b0, '0, '0, '0);
      directed_count = requests.size();
      build_random_requests(RANDOM_REQUESTS);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < requests.size(); i++) begin
         if (i >= directed_count && (i - directed_count) % PHASE_LENGTH == 0) begin
            phase = (i - directed_count) / PHASE_LENGTH;
            case (phase)
               0: begin
                  sender_idle_pct = 0;
                  receiver_stall_pct = 0;
                  long_hold_request = 1'b1;
               end
               1: begin
                  sender_idle_pct = 46;
                  receiver_stall_pct = 0;
               end
               2: begin
                  sender_idle_pct = 0;
                  receiver_stall_pct = 46;
               end
               default: begin
                  sender_idle_pct = 38;
                  receiver_stall_pct = 38;
               end
            endcase
         end
         while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_button_levels <= requests[i].levels;
         req_encoder_sample <= requests[i].enc;
         do @(posedge clock); while (!req_ready);
         predicted = advance_counter(requests[i].levels, requests[i].enc);
         pending_readings.push_back(requests[i].fixed ? requests[i].reading : predicted);
         requests_sent++;
      end
      req_valid <= 1'b0;

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results: %0d button presses, %0d encoder turns",
               requests_sent, readings_checked, presses_seen, turns_seen);
      $display("step sizes seen (bit per step) %b, four idle mixes and one long hold-off",
               steps_seen);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench: FAIL");
      end
      $finish;
   end

   // result side
   initial begin
      int          hold_left;
      reading_type got;
      reading_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_count, rsp_step_size, rsp_bargraph_pattern};
            readings_checked++;
            steps_seen[rsp_step_size] = 1'b1;
            if (pending_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: count %0d step %0d bargraph %h",
                           got.count, got.step, got.bar);
            end else begin
               want = pending_readings.pop_front();
               if (got.count !== want.count || got.step !== want.step
                   || got.bar !== want.bar) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("result %0d: expected count %0d step %0d bargraph %h, %s %0d %0d %h",
                              readings_checked, want.count, want.step, want.bar,
                              "got", got.count, got.step, got.bar);
               end
            end
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog: drop out when no request or result moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

endmodule
